### hdl/wat_pkg.sv
// wat_pkg: types, constants and the uniform-value table of the weighted action table.
// Used by every module of the block; depends on nothing.
`default_nettype none
package wat_pkg;

	localparam int MAX_STATES  = 64;
	localparam int MAX_ACTIONS = 16;
	localparam int ROW_W   = 6;
	localparam int ACT_W   = 4;
	localparam int ADDR_W  = ROW_W + ACT_W;
	localparam int ENTRY_W = 17;
	localparam int SUM_W   = 21;
	localparam int AMT_W   = 24;
	localparam int DRAW_W  = 16;
	localparam int DEPTH   = MAX_STATES * MAX_ACTIONS;
	localparam int QBITS   = 17;

	localparam logic [1:0] CMD_QUERY = 2'd0;
	localparam logic [1:0] CMD_SCALE = 2'd1;
	localparam logic [1:0] CMD_ADD   = 2'd2;
	localparam logic [1:0] CMD_RESET = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_ZERO = 2'd2;

	localparam logic REG_STATES  = 1'b0;
	localparam logic REG_ACTIONS = 1'b1;

	localparam logic [1:0] ADDR_SWEEP = 2'd0;
	localparam logic [1:0] ADDR_ROW_J = 2'd1;
	localparam logic [1:0] ADDR_ENTRY = 2'd2;

	localparam logic [1:0] WD_FILL = 2'd0;
	localparam logic [1:0] WD_UPD  = 2'd1;
	localparam logic [1:0] WD_UNI  = 2'd2;
	localparam logic [1:0] WD_QUO  = 2'd3;

	localparam logic [ENTRY_W-1:0] ENTRY_MAX = 17'd131071;
	localparam logic [ENTRY_W-1:0] UNIFORM_RESET = 17'd4096;

	typedef struct packed {
		logic [1:0]              command;
		logic [ROW_W-1:0]        row_index;
		logic [ACT_W-1:0]        action_index;
		logic signed [AMT_W-1:0] amount;
		logic [DRAW_W-1:0]       random_draw;
	} item_t;

	typedef struct packed {
		logic [ACT_W-1:0] chosen_action;
		logic [1:0]       status;
	} result_t;

	typedef struct packed {
		logic       take;
		logic       cnt_clr;
		logic       cnt_inc;
		logic       sum_clr;
		logic       sum_acc;
		logic       mul_en;
		logic       div_load;
		logic       div_step;
		logic       mem_we;
		logic [1:0] addr_sel;
		logic [1:0] wd_sel;
		logic       fill_load;
		logic       res_set;
		logic [1:0] res_code;
		logic       res_pick;
		logic       out_load;
	} ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       row_bad;
		logic       act_bad;
		logic       hit;
		logic       last;
		logic       sweep_last;
		logic       sum_zero;
		logic       div_last;
	} sts_t;

	// floor(65536 / a) for an effective action count of 1 to 16
	function automatic logic [ENTRY_W-1:0] uniform_q16(input logic [4:0] a);
		logic [ENTRY_W-1:0] v;
		unique case (a)
			5'd1:    v = 17'd65536;
			5'd2:    v = 17'd32768;
			5'd3:    v = 17'd21845;
			5'd4:    v = 17'd16384;
			5'd5:    v = 17'd13107;
			5'd6:    v = 17'd10922;
			5'd7:    v = 17'd9362;
			5'd8:    v = 17'd8192;
			5'd9:    v = 17'd7281;
			5'd10:   v = 17'd6553;
			5'd11:   v = 17'd5957;
			5'd12:   v = 17'd5461;
			5'd13:   v = 17'd5041;
			5'd14:   v = 17'd4681;
			5'd15:   v = 17'd4369;
			5'd16:   v = 17'd4096;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### hdl/wat_ctrl.sv
// wat_ctrl: sequencer of the weighted action table.
// Depends on wat_pkg; drives wat_datapath through ctl_t, reads sts_t.
`default_nettype none
module wat_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_stall,
	output logic              res_valid,
	input  wire logic         res_stall,
	input  wire wat_pkg::sts_t sts,
	output wat_pkg::ctl_t     ctl
);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_DEC  = 5'd2;
	localparam logic [4:0] S_FILL = 5'd3;
	localparam logic [4:0] S_QA   = 5'd4;
	localparam logic [4:0] S_QC   = 5'd5;
	localparam logic [4:0] S_RRD  = 5'd6;
	localparam logic [4:0] S_RMUL = 5'd7;
	localparam logic [4:0] S_RUPD = 5'd8;
	localparam logic [4:0] S_SA   = 5'd9;
	localparam logic [4:0] S_SC   = 5'd10;
	localparam logic [4:0] S_SZ   = 5'd11;
	localparam logic [4:0] S_Z    = 5'd12;
	localparam logic [4:0] S_DA   = 5'd13;
	localparam logic [4:0] S_DL   = 5'd14;
	localparam logic [4:0] S_DS   = 5'd15;
	localparam logic [4:0] S_DW   = 5'd16;
	localparam logic [4:0] S_DONE = 5'd17;

	logic [4:0] state_q, state_nx;
	logic       res_valid_q;

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_CLR: begin
				ctl.mem_we   = 1'b1;
				ctl.addr_sel = wat_pkg::ADDR_SWEEP;
				ctl.wd_sel   = wat_pkg::WD_FILL;
				ctl.cnt_inc  = 1'b1;
				if (sts.sweep_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.take = 1'b1;
					state_nx = S_DEC;
				end
			end
			S_DEC: begin
				ctl.cnt_clr = 1'b1;
				ctl.sum_clr = 1'b1;
				priority if (sts.cmd == wat_pkg::CMD_RESET) begin
					ctl.fill_load = 1'b1;
					state_nx      = S_FILL;
				end else if (sts.row_bad) begin
					ctl.res_set  = 1'b1;
					ctl.res_code = wat_pkg::ST_BAD;
					state_nx     = S_DONE;
				end else if (sts.cmd == wat_pkg::CMD_QUERY) begin
					state_nx = S_QA;
				end else if (sts.act_bad) begin
					ctl.res_set  = 1'b1;
					ctl.res_code = wat_pkg::ST_BAD;
					state_nx     = S_DONE;
				end else begin
					state_nx = S_RRD;
				end
			end
			S_FILL: begin
				ctl.mem_we   = 1'b1;
				ctl.addr_sel = wat_pkg::ADDR_SWEEP;
				ctl.wd_sel   = wat_pkg::WD_FILL;
				ctl.cnt_inc  = 1'b1;
				if (sts.sweep_last) begin
					ctl.res_set  = 1'b1;
					ctl.res_code = wat_pkg::ST_OK;
					state_nx     = S_DONE;
				end
			end
			S_QA: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				state_nx     = S_QC;
			end
			S_QC: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				ctl.sum_acc  = 1'b1;
				if (sts.hit || sts.last) begin
					ctl.res_set  = 1'b1;
					ctl.res_code = wat_pkg::ST_OK;
					ctl.res_pick = 1'b1;
					state_nx     = S_DONE;
				end else begin
					ctl.cnt_inc = 1'b1;
					state_nx    = S_QA;
				end
			end
			S_RRD: begin
				ctl.addr_sel = wat_pkg::ADDR_ENTRY;
				state_nx     = S_RMUL;
			end
			S_RMUL: begin
				ctl.addr_sel = wat_pkg::ADDR_ENTRY;
				ctl.mul_en   = 1'b1;
				state_nx     = S_RUPD;
			end
			S_RUPD: begin
				ctl.addr_sel = wat_pkg::ADDR_ENTRY;
				ctl.wd_sel   = wat_pkg::WD_UPD;
				ctl.mem_we   = 1'b1;
				state_nx     = S_SA;
			end
			S_SA: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				state_nx     = S_SC;
			end
			S_SC: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				ctl.sum_acc  = 1'b1;
				if (sts.last) begin
					ctl.cnt_clr = 1'b1;
					state_nx    = S_SZ;
				end else begin
					ctl.cnt_inc = 1'b1;
					state_nx    = S_SA;
				end
			end
			S_SZ: begin
				state_nx = sts.sum_zero ? S_Z : S_DA;
			end
			S_Z: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				ctl.wd_sel   = wat_pkg::WD_UNI;
				ctl.mem_we   = 1'b1;
				ctl.cnt_inc  = 1'b1;
				if (sts.last) begin
					ctl.res_set  = 1'b1;
					ctl.res_code = wat_pkg::ST_ZERO;
					state_nx     = S_DONE;
				end
			end
			S_DA: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				state_nx     = S_DL;
			end
			S_DL: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				ctl.div_load = 1'b1;
				state_nx     = S_DS;
			end
			S_DS: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				ctl.div_step = 1'b1;
				if (sts.div_last) state_nx = S_DW;
			end
			S_DW: begin
				ctl.addr_sel = wat_pkg::ADDR_ROW_J;
				ctl.wd_sel   = wat_pkg::WD_QUO;
				ctl.mem_we   = 1'b1;
				ctl.cnt_inc  = 1'b1;
				if (sts.last) begin
					ctl.res_set  = 1'b1;
					ctl.res_code = wat_pkg::ST_OK;
					state_nx     = S_DONE;
				end else begin
					state_nx = S_DA;
				end
			end
			S_DONE: begin
				if (!res_valid_q || !res_stall) begin
					ctl.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.out_load) res_valid_q <= 1'b1;
			else if (!res_stall) res_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

### hdl/wat_datapath.sv
// wat_datapath: probability memory, accumulator, multiplier, divider, result registers.
// Depends on wat_pkg; steered by wat_ctrl through ctl_t.
`default_nettype none
module wat_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire wat_pkg::ctl_t   ctl,
	output wat_pkg::sts_t        sts,
	input  wire wat_pkg::item_t  cmd_item,
	output wat_pkg::result_t     res_item,
	input  wire logic            cfg_we,
	input  wire logic            cfg_index,
	input  wire logic [6:0]      cfg_data
);

	logic [wat_pkg::ENTRY_W-1:0] mem [wat_pkg::DEPTH];
	logic [wat_pkg::ENTRY_W-1:0] rd_q, cur_q, wd, nv, fill_val_q, quo_q;
	logic [wat_pkg::ADDR_W-1:0]  cnt_q, addr;
	logic [wat_pkg::SUM_W-1:0]   sum_q, sum_nx, rem_q;
	logic [wat_pkg::QBITS-1:0]   dvd_q;
	logic [4:0]                  div_cnt_q;
	logic [wat_pkg::SUM_W:0]     shifted;
	logic                        ge;
	logic signed [41:0]          prod, prod_q;
	logic signed [24:0]          add_v;
	logic [6:0]                  states_q, eff_states;
	logic [4:0]                  actions_q, eff_act, act_m1;
	wat_pkg::item_t              item_q;
	wat_pkg::result_t            res_q, out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			states_q  <= 7'(wat_pkg::MAX_STATES);
			actions_q <= 5'(wat_pkg::MAX_ACTIONS);
		end else if (cfg_we) begin
			if (cfg_index == wat_pkg::REG_STATES) states_q <= cfg_data;
			else actions_q <= cfg_data[4:0];
		end
	end

	assign eff_states = (states_q == 7'd0) ? 7'd1 :
		(states_q > 7'(wat_pkg::MAX_STATES)) ? 7'(wat_pkg::MAX_STATES) : states_q;
	assign eff_act = (actions_q == 5'd0) ? 5'd1 :
		(actions_q > 5'(wat_pkg::MAX_ACTIONS)) ? 5'(wat_pkg::MAX_ACTIONS) : actions_q;
	assign act_m1 = eff_act - 5'd1;

	always_comb begin
		unique case (ctl.addr_sel)
			wat_pkg::ADDR_ROW_J: addr = {item_q.row_index, cnt_q[wat_pkg::ACT_W-1:0]};
			wat_pkg::ADDR_ENTRY: addr = {item_q.row_index, item_q.action_index};
			default:             addr = cnt_q;
		endcase
	end

	// reinforce: clamp at zero, saturate at the entry maximum
	assign prod  = $signed({1'b0, rd_q}) * item_q.amount;
	assign add_v = $signed({8'b0, cur_q}) + $signed({item_q.amount[23], item_q.amount});
	always_comb begin
		if (item_q.command == wat_pkg::CMD_SCALE) begin
			if (prod_q <= 42'sd0) nv = '0;
			else if (prod_q[41:16] > {9'b0, wat_pkg::ENTRY_MAX}) nv = wat_pkg::ENTRY_MAX;
			else nv = prod_q[32:16];
		end else begin
			if (add_v < 25'sd0) nv = '0;
			else if (add_v > $signed({8'b0, wat_pkg::ENTRY_MAX})) nv = wat_pkg::ENTRY_MAX;
			else nv = add_v[16:0];
		end
	end

	always_comb begin
		unique case (ctl.wd_sel)
			wat_pkg::WD_UPD: wd = nv;
			wat_pkg::WD_UNI: wd = wat_pkg::uniform_q16(eff_act);
			wat_pkg::WD_QUO: wd = quo_q;
			default:         wd = fill_val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_we) mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	assign sum_nx  = sum_q + {4'b0, rd_q};
	// restoring divider, one quotient bit a cycle
	assign shifted = {rem_q, dvd_q[wat_pkg::QBITS-1]};
	assign ge      = shifted >= {1'b0, sum_q};

	always_ff @(posedge clk) begin
		if (ctl.take) item_q <= cmd_item;
		if (ctl.mul_en) begin
			prod_q <= prod;
			cur_q  <= rd_q;
		end
		if (ctl.sum_clr) sum_q <= '0;
		else if (ctl.sum_acc) sum_q <= sum_nx;
		if (ctl.div_load) begin
			rem_q     <= {5'b0, rd_q[16:1]};
			dvd_q     <= {rd_q[0], 16'b0};
			quo_q     <= '0;
			div_cnt_q <= '0;
		end else if (ctl.div_step) begin
			rem_q     <= ge ? wat_pkg::SUM_W'(shifted - {1'b0, sum_q})
				: shifted[wat_pkg::SUM_W-1:0];
			dvd_q     <= {dvd_q[wat_pkg::QBITS-2:0], 1'b0};
			quo_q     <= {quo_q[wat_pkg::QBITS-2:0], ge};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
		if (ctl.res_set) begin
			res_q.status        <= ctl.res_code;
			res_q.chosen_action <= ctl.res_pick ? cnt_q[wat_pkg::ACT_W-1:0] : '0;
		end
		if (ctl.out_load) out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			fill_val_q <= wat_pkg::UNIFORM_RESET;
		end else begin
			if (ctl.cnt_clr) cnt_q <= '0;
			else if (ctl.cnt_inc) cnt_q <= cnt_q + 1'b1;
			if (ctl.fill_load) fill_val_q <= wat_pkg::uniform_q16(eff_act);
		end
	end

	assign res_item       = out_q;
	assign sts.cmd        = item_q.command;
	assign sts.row_bad    = {1'b0, item_q.row_index} >= eff_states;
	assign sts.act_bad    = {1'b0, item_q.action_index} >= eff_act;
	assign sts.hit        = {5'b0, item_q.random_draw} <= sum_nx;
	assign sts.last       = cnt_q[wat_pkg::ACT_W-1:0] == act_m1[wat_pkg::ACT_W-1:0];
	assign sts.sweep_last = &cnt_q;
	assign sts.sum_zero   = (sum_q == '0);
	assign sts.div_last   = (div_cnt_q == 5'(wat_pkg::QBITS - 1));

endmodule
`default_nettype wire

### hdl/weighted_action_table_unit.sv
// weighted_action_table_unit: top level of the weighted action table.
// Depends on wat_pkg, wat_ctrl and wat_datapath.
//
// Usage notes:
//  - cmd channel (cmd_valid/cmd_stall/cmd_item) takes one command item; an
//    item is taken on a clock edge with cmd_valid high and cmd_stall low.
//  - res channel (res_valid/res_stall/res_item) gives one result item per
//    command, in order. res_item holds while res_valid and res_stall are high.
//  - cfg_we/cfg_index/cfg_data write states_in_use (0) and actions_in_use (1);
//    write only when the block is idle. Writes do not refill the table.
//  - One item at a time. What each command does, with n actions in use:
//      bad index: the result is set at once; query: walks up to n entries;
//      reinforce: updates the entry, then a row sum, then a 17-step divider per
//      entry over the shared memory port; zero row: writes the uniform value
//      to each of the n entries; reset-uniform: fills the whole table, one
//      entry a cycle through the single-port table memory.
//  - After reset the table is cleared to 1/16 by a pass over every entry; cmd_stall
//    stays high until it ends. Configuration writes are taken meanwhile.
//  - A stalled result blocks only the finish of the next item: a new item
//    is taken while the previous result waits in the output register.
`default_nettype none
module weighted_action_table_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire wat_pkg::item_t    cmd_item,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output wat_pkg::result_t       res_item,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [6:0]        cfg_data
);

	wat_pkg::ctl_t ctl;
	wat_pkg::sts_t sts;

	wat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	wat_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_item  (cmd_item),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

### hdl/wat_checker.sv
// wat_checker: port-level checks of weighted_action_table_unit, and its bind.
// Depends on wat_pkg.
`default_nettype none
module wat_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cmd_valid,
	input wire logic             cmd_stall,
	input wire logic             res_valid,
	input wire logic             res_stall,
	input wire wat_pkg::result_t res_item
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_item))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("second item taken before first decoded");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_item.status != 2'd3) &&
		(res_item.status == wat_pkg::ST_OK || res_item.chosen_action == '0))
		else $error("bad status or action on result");

endmodule

bind weighted_action_table_unit wat_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_item  (res_item)
);
`default_nettype wire
